FILE: rtl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// Shared sizes, result codes and controller command type for the priority
// ready queue with its overflow FIFO.
// ----------------------------------------------------------------------------
package prq_pkg;

	// Store depths
	localparam int READY_DEPTH = 8;
	localparam int WAIT_DEPTH  = 8;

	// Index and count widths (an index stays at least one bit wide)
	localparam int RIDX_W = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
	localparam int WIDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int RCNT_W = $clog2(READY_DEPTH + 1);
	localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);

	// Field widths
	localparam int ID_W   = 8;
	localparam int PRIO_W = 8;
	localparam int STAT_W = 3;
	localparam int CNT_W  = 4;

	// Input kinds
	localparam logic KIND_SUBMIT   = 1'b0;
	localparam logic KIND_DISPATCH = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_QUEUED_READY = 3'd0;
	localparam logic [STAT_W-1:0] ST_QUEUED_WAIT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_REJECTED     = 3'd2;
	localparam logic [STAT_W-1:0] ST_DISPATCHED   = 3'd3;
	localparam logic [STAT_W-1:0] ST_READY_EMPTY  = 3'd4;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture; // latch the accepted input word
		logic find;    // register the index of the best ready entry
		logic commit;  // update the stores and load the output register
	} prq_cmd_t;

endpackage

FILE: rtl/priority_ready_queue_with_overflow_fifo.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_with_overflow_fifo
// Task scheduler: age-ordered ready list served lowest priority first, with
// a waiting FIFO that takes the overflow and refills the list on dispatch.
//
// Channel | Handshake             | Word
// --------+-----------------------+---------------------------------------------
// in      | in_valid / in_stall   | kind, task_id, task_priority
// out     | out_valid / out_stall | status, out_task_id, out_priority,
//         |                       | moved_valid, moved_task_id, ready_count,
//         |                       | waiting_count
//
// Each word passes a search of the ready list for its minimum (linear compare
// over the occupied entries, registered in the find state), then a commit that
// updates the stores and loads the output register; a new word is taken in the commit cycle.
// Reset empties both stores at once through their counts; no clearing pass.
// A held output word stalls the commit, and with it the input channel.
// ----------------------------------------------------------------------------
module priority_ready_queue_with_overflow_fifo import prq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [ID_W-1:0]   task_id,
	input  logic [PRIO_W-1:0] task_priority,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic [ID_W-1:0]   out_task_id,
	output logic [PRIO_W-1:0] out_priority,
	output logic              moved_valid,
	output logic [ID_W-1:0]   moved_task_id,
	output logic [CNT_W-1:0]  ready_count,
	output logic [CNT_W-1:0]  waiting_count
);

	prq_cmd_t cmd;

	// Sequencer
	prq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Stores and result path
	prq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.kind          (kind),
		.task_id       (task_id),
		.task_priority (task_priority),
		.status        (status),
		.out_task_id   (out_task_id),
		.out_priority  (out_priority),
		.moved_valid   (moved_valid),
		.moved_task_id (moved_task_id),
		.ready_count   (ready_count),
		.waiting_count (waiting_count)
	);

endmodule

FILE: rtl/prq_ctrl.sv
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer: accept, search the ready list, commit. Owns the output valid
// flag and the input stall signal.
// ----------------------------------------------------------------------------
module prq_ctrl import prq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output prq_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_FIND   = 3'b010,
		S_COMMIT = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_go;
	logic   accept;

	// Output register can take a new word this cycle
	assign out_go   = !out_valid_q || !out_stall;
	// Input is open when idle, or when the commit finishes this cycle
	assign in_stall = !((state_q == S_IDLE) || ((state_q == S_COMMIT) && out_go));
	assign accept   = in_valid && !in_stall;

	assign cmd.capture = accept;
	assign cmd.find    = (state_q == S_FIND);
	assign cmd.commit  = (state_q == S_COMMIT) && out_go;

	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_FIND;
			end
			S_FIND: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (out_go) state_d = accept ? S_FIND : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/prq_dp.sv
// ----------------------------------------------------------------------------
// prq_dp
// Datapath: input word register, ready list (age ordered, compacting),
// circular waiting FIFO, minimum search and output register.
// ----------------------------------------------------------------------------
module prq_dp import prq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  prq_cmd_t          cmd,
	input  logic              kind,
	input  logic [ID_W-1:0]   task_id,
	input  logic [PRIO_W-1:0] task_priority,
	output logic [STAT_W-1:0] status,
	output logic [ID_W-1:0]   out_task_id,
	output logic [PRIO_W-1:0] out_priority,
	output logic              moved_valid,
	output logic [ID_W-1:0]   moved_task_id,
	output logic [CNT_W-1:0]  ready_count,
	output logic [CNT_W-1:0]  waiting_count
);

	// Captured input word
	logic              kind_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;

	// Ready list, entry 0 oldest
	logic [ID_W-1:0]   rid_q   [READY_DEPTH];
	logic [PRIO_W-1:0] rprio_q [READY_DEPTH];
	logic [ID_W-1:0]   rid_d   [READY_DEPTH];
	logic [PRIO_W-1:0] rprio_d [READY_DEPTH];
	logic [RCNT_W-1:0] rused_q, rused_d;

	// Waiting FIFO
	logic [ID_W-1:0]   wid_q   [WAIT_DEPTH];
	logic [PRIO_W-1:0] wprio_q [WAIT_DEPTH];
	logic [ID_W-1:0]   wid_d   [WAIT_DEPTH];
	logic [PRIO_W-1:0] wprio_d [WAIT_DEPTH];
	logic [WIDX_W-1:0] whead_q, whead_d;
	logic [WIDX_W-1:0] wtail_q, wtail_d;
	logic [WCNT_W-1:0] wused_q, wused_d;

	// Search result
	logic [RIDX_W-1:0] best;
	logic [PRIO_W-1:0] best_prio;
	logic [RIDX_W-1:0] best_s1;

	// Output word
	logic [STAT_W-1:0] st_d, st_q;
	logic [ID_W-1:0]   oid_d, oid_q;
	logic [PRIO_W-1:0] oprio_d, oprio_q;
	logic              mv_d, mv_q;
	logic [ID_W-1:0]   mid_d, mid_q;
	logic [CNT_W-1:0]  rcnt_q, wcnt_q;

	// Lowest priority among occupied entries; strict compare keeps the oldest
	always_comb begin
		best      = '0;
		best_prio = rprio_q[0];
		for (int i = 1; i < READY_DEPTH; i++) begin
			if ((RCNT_W'(i) < rused_q) && (rprio_q[RIDX_W'(i)] < best_prio)) begin
				best      = RIDX_W'(i);
				best_prio = rprio_q[RIDX_W'(i)];
			end
		end
	end

	// Commit: next store contents and the result word
	always_comb begin
		rid_d   = rid_q;
		rprio_d = rprio_q;
		rused_d = rused_q;
		wid_d   = wid_q;
		wprio_d = wprio_q;
		whead_d = whead_q;
		wtail_d = wtail_q;
		wused_d = wused_q;
		st_d    = ST_READY_EMPTY;
		oid_d   = '0;
		oprio_d = '0;
		mv_d    = 1'b0;
		mid_d   = '0;
		if (kind_q == KIND_SUBMIT) begin
			oid_d   = id_q;
			oprio_d = prio_q;
			if (rused_q < RCNT_W'(READY_DEPTH)) begin
				rid_d[RIDX_W'(rused_q)]   = id_q;
				rprio_d[RIDX_W'(rused_q)] = prio_q;
				rused_d = rused_q + 1'b1;
				st_d    = ST_QUEUED_READY;
			end else if (wused_q < WCNT_W'(WAIT_DEPTH)) begin
				wid_d[wtail_q]   = id_q;
				wprio_d[wtail_q] = prio_q;
				wtail_d = (wtail_q == WIDX_W'(WAIT_DEPTH - 1)) ? '0 : wtail_q + 1'b1;
				wused_d = wused_q + 1'b1;
				st_d    = ST_QUEUED_WAIT;
			end else begin
				st_d = ST_REJECTED;
			end
		end else if (rused_q != '0) begin
			st_d    = ST_DISPATCHED;
			oid_d   = rid_q[best_s1];
			oprio_d = rprio_q[best_s1];
			// close the gap behind the removed entry
			for (int i = 0; i < READY_DEPTH - 1; i++) begin
				if (RIDX_W'(i) >= best_s1) begin
					rid_d[RIDX_W'(i)]   = rid_q[RIDX_W'(i + 1)];
					rprio_d[RIDX_W'(i)] = rprio_q[RIDX_W'(i + 1)];
				end
			end
			rused_d = rused_q - 1'b1;
			// refill from the waiting FIFO head
			if (wused_q != '0) begin
				rid_d[RIDX_W'(rused_q - 1'b1)]   = wid_q[whead_q];
				rprio_d[RIDX_W'(rused_q - 1'b1)] = wprio_q[whead_q];
				rused_d = rused_q;
				whead_d = (whead_q == WIDX_W'(WAIT_DEPTH - 1)) ? '0 : whead_q + 1'b1;
				wused_d = wused_q - 1'b1;
				mv_d    = 1'b1;
				mid_d   = wid_q[whead_q];
			end
		end
	end

	// Pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rused_q <= '0;
			whead_q <= '0;
			wtail_q <= '0;
			wused_q <= '0;
		end else if (cmd.commit) begin
			rused_q <= rused_d;
			whead_q <= whead_d;
			wtail_q <= wtail_d;
			wused_q <= wused_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			id_q   <= task_id;
			prio_q <= task_priority;
		end
		if (cmd.find) begin
			best_s1 <= best;
		end
		if (cmd.commit) begin
			rid_q   <= rid_d;
			rprio_q <= rprio_d;
			wid_q   <= wid_d;
			wprio_q <= wprio_d;
			st_q    <= st_d;
			oid_q   <= oid_d;
			oprio_q <= oprio_d;
			mv_q    <= mv_d;
			mid_q   <= mid_d;
			rcnt_q  <= CNT_W'(rused_d);
			wcnt_q  <= CNT_W'(wused_d);
		end
	end

	assign status        = st_q;
	assign out_task_id   = oid_q;
	assign out_priority  = oprio_q;
	assign moved_valid   = mv_q;
	assign moved_task_id = mid_q;
	assign ready_count   = rcnt_q;
	assign waiting_count = wcnt_q;

endmodule

FILE: test/priority_ready_queue_with_overflow_fifo_tb.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_with_overflow_fifo_tb
// Self-checking bench for the task scheduler. A directed table exercises the
// empty, full and rejected cases, priority ties and the refill from the
// waiting FIFO. A long random run follows, in bursts that fill and drain the
// stores. Every result word is checked against its fixed row or a behavioral
// scheduler in the bench, under phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module priority_ready_queue_with_overflow_fifo_tb;
	import prq_pkg::*;

	localparam int RAND_WORDS  = 1924;
	localparam int PHASE_LEN   = RAND_WORDS / 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_LIMIT = 40;
	localparam int DIR_ROWS    = 25;

	// One result word
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ID_W-1:0]   tid;
		logic [PRIO_W-1:0] prio;
		logic              moved;
		logic [ID_W-1:0]   moved_id;
		logic [CNT_W-1:0]  rdy_cnt;
		logic [CNT_W-1:0]  wait_cnt;
	} sched_word_t;

	// One row of the directed table; fixed rows carry their own result
	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   tid;
		logic [PRIO_W-1:0] prio;
		logic              fixed;
		sched_word_t       res;
	} dir_row_t;

	// Burst shapes of the random part
	typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              kind;
	logic [ID_W-1:0]   task_id;
	logic [PRIO_W-1:0] task_priority;
	logic              out_valid;
	logic              out_stall;
	logic [STAT_W-1:0] status;
	logic [ID_W-1:0]   out_task_id;
	logic [PRIO_W-1:0] out_priority;
	logic              moved_valid;
	logic [ID_W-1:0]   moved_task_id;
	logic [CNT_W-1:0]  ready_count;
	logic [CNT_W-1:0]  waiting_count;

	// Bench-side tag driven along with each input word
	logic        word_fixed;
	sched_word_t word_fixed_res;

	// Scheduler state mirrored in the bench
	logic [ID_W-1:0]   rdy_id   [READY_DEPTH];
	logic [PRIO_W-1:0] rdy_prio [READY_DEPTH];
	int                rdy_n;
	logic [ID_W-1:0]   wq_id    [WAIT_DEPTH];
	logic [PRIO_W-1:0] wq_prio  [WAIT_DEPTH];
	int                wq_head;
	int                wq_tail;
	int                wq_n;

	sched_word_t results_due[$];
	dir_row_t    dir_rows[DIR_ROWS];

	int errors;
	int cycles;
	int send_idle_pct;
	int stall_pct;
	int n_submit, n_to_wait, n_rejected, n_dispatch, n_empty, n_refill;

	priority_ready_queue_with_overflow_fifo DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.task_id       (task_id),
		.task_priority (task_priority),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.out_task_id   (out_task_id),
		.out_priority  (out_priority),
		.moved_valid   (moved_valid),
		.moved_task_id (moved_task_id),
		.ready_count   (ready_count),
		.waiting_count (waiting_count)
	);

	// Clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver stalls
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Mismatch report: one line per mismatch, printing capped
	task automatic flag_mismatch(input string what, input logic [31:0] want_v,
		input logic [31:0] got_v);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s expected %0h got %0h", cycles, what,
				want_v, got_v);
	endtask

	// Scheduler: applies one word to the mirrored state, returns its result
	function automatic sched_word_t schedule_word(input logic k,
		input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] pr);
		sched_word_t r;
		int          best;
		r = '0;
		if (k == KIND_SUBMIT) begin
			r.tid  = id;
			r.prio = pr;
			if (rdy_n < READY_DEPTH) begin
				rdy_id[rdy_n]   = id;
				rdy_prio[rdy_n] = pr;
				rdy_n++;
				r.status = ST_QUEUED_READY;
			end else if (wq_n < WAIT_DEPTH) begin
				wq_id[wq_tail]   = id;
				wq_prio[wq_tail] = pr;
				wq_tail = (wq_tail + 1) % WAIT_DEPTH;
				wq_n++;
				r.status = ST_QUEUED_WAIT;
			end else begin
				r.status = ST_REJECTED;
			end
		end else if (rdy_n == 0) begin
			r.status = ST_READY_EMPTY;
		end else begin
			// lowest priority wins, strict compare keeps the oldest on a tie
			best = 0;
			for (int i = 1; i < rdy_n; i++)
				if (rdy_prio[i] < rdy_prio[best])
					best = i;
			r.tid  = rdy_id[best];
			r.prio = rdy_prio[best];
			for (int i = best; i + 1 < rdy_n; i++) begin
				rdy_id[i]   = rdy_id[i + 1];
				rdy_prio[i] = rdy_prio[i + 1];
			end
			rdy_n--;
			r.status = ST_DISPATCHED;
			// refill from the head of the waiting FIFO
			if (wq_n > 0) begin
				r.moved    = 1'b1;
				r.moved_id = wq_id[wq_head];
				rdy_id[rdy_n]   = wq_id[wq_head];
				rdy_prio[rdy_n] = wq_prio[wq_head];
				rdy_n++;
				wq_head = (wq_head + 1) % WAIT_DEPTH;
				wq_n--;
			end
		end
		r.rdy_cnt  = CNT_W'(rdy_n);
		r.wait_cnt = CNT_W'(wq_n);
		return r;
	endfunction

	// Accepted input words feed the scheduler; accepted results are checked
	always @(posedge clk) begin : monitor
		sched_word_t pred;
		sched_word_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pred = schedule_word(kind, task_id, task_priority);
				results_due.push_back(word_fixed ? word_fixed_res : pred);
				case (pred.status)
					ST_QUEUED_READY: n_submit++;
					ST_QUEUED_WAIT:  begin n_submit++; n_to_wait++; end
					ST_REJECTED:     begin n_submit++; n_rejected++; end
					ST_DISPATCHED:   begin n_dispatch++; n_refill += pred.moved; end
					ST_READY_EMPTY:  begin n_dispatch++; n_empty++; end
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					flag_mismatch("unexpected word, status", '0, 32'(status));
				end else begin
					want = results_due.pop_front();
					if (status !== want.status)
						flag_mismatch("status", 32'(want.status), 32'(status));
					if (out_task_id !== want.tid)
						flag_mismatch("out_task_id", 32'(want.tid), 32'(out_task_id));
					if (out_priority !== want.prio)
						flag_mismatch("out_priority", 32'(want.prio), 32'(out_priority));
					if (moved_valid !== want.moved)
						flag_mismatch("moved_valid", 32'(want.moved), 32'(moved_valid));
					if (moved_task_id !== want.moved_id)
						flag_mismatch("moved_task_id", 32'(want.moved_id),
							32'(moved_task_id));
					if (ready_count !== want.rdy_cnt)
						flag_mismatch("ready_count", 32'(want.rdy_cnt), 32'(ready_count));
					if (waiting_count !== want.wait_cnt)
						flag_mismatch("waiting_count", 32'(want.wait_cnt),
							32'(waiting_count));
				end
			end
		end
	end

	// Present one word at a falling edge and hold it until taken
	task automatic send_word(input logic k, input logic [ID_W-1:0] id,
		input logic [PRIO_W-1:0] pr, input logic fx, input sched_word_t res);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		kind           <= k;
		task_id        <= id;
		task_priority  <= pr;
		word_fixed     <= fx;
		word_fixed_res <= res;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stimulus
	initial begin : stim
		mix_t              mix;
		int                sub_pct;
		logic              k;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] pr;

		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		kind           = KIND_SUBMIT;
		task_id        = '0;
		task_priority  = '0;
		out_stall      = 1'b0;
		word_fixed     = 1'b0;
		word_fixed_res = '0;
		send_idle_pct  = 0;
		stall_pct      = 0;
		errors         = 0;
		cycles         = 0;
		rdy_n          = 0;
		wq_head        = 0;
		wq_tail        = 0;
		wq_n           = 0;
		mix            = MIX_EVEN;
		n_submit = 0; n_to_wait = 0; n_rejected = 0;
		n_dispatch = 0; n_empty = 0; n_refill = 0;

		// dispatch on empty, extremes, ties, fill both stores, reject, dispatch with refill
		dir_rows = '{
			'{KIND_DISPATCH, 8'h00, 8'h00, 1'b1,
				'{ST_READY_EMPTY, 8'h00, 8'h00, 1'b0, 8'h00, 4'd0, 4'd0}},
			'{KIND_SUBMIT, 8'hFF, 8'h00, 1'b1,
				'{ST_QUEUED_READY, 8'hFF, 8'h00, 1'b0, 8'h00, 4'd1, 4'd0}},
			'{KIND_SUBMIT, 8'h00, 8'hFF, 1'b1,
				'{ST_QUEUED_READY, 8'h00, 8'hFF, 1'b0, 8'h00, 4'd2, 4'd0}},
			'{KIND_SUBMIT, 8'h11, 8'h40, 1'b0, '0},
			'{KIND_SUBMIT, 8'h12, 8'h40, 1'b0, '0},
			'{KIND_SUBMIT, 8'h13, 8'h10, 1'b0, '0},
			'{KIND_SUBMIT, 8'h14, 8'h10, 1'b0, '0},
			'{KIND_SUBMIT, 8'h15, 8'hFF, 1'b0, '0},
			'{KIND_SUBMIT, 8'h16, 8'h80, 1'b0, '0},
			'{KIND_SUBMIT, 8'h21, 8'h05, 1'b0, '0},
			'{KIND_SUBMIT, 8'h22, 8'h00, 1'b0, '0},
			'{KIND_SUBMIT, 8'h23, 8'hFF, 1'b0, '0},
			'{KIND_SUBMIT, 8'h24, 8'h05, 1'b0, '0},
			'{KIND_SUBMIT, 8'h25, 8'h7F, 1'b0, '0},
			'{KIND_SUBMIT, 8'h26, 8'h00, 1'b0, '0},
			'{KIND_SUBMIT, 8'h27, 8'h01, 1'b0, '0},
			'{KIND_SUBMIT, 8'h28, 8'hFE, 1'b0, '0},
			'{KIND_SUBMIT, 8'hAA, 8'h55, 1'b1,
				'{ST_REJECTED, 8'hAA, 8'h55, 1'b0, 8'h00, 4'd8, 4'd8}},
			'{KIND_DISPATCH, 8'h5A, 8'hA5, 1'b0, '0},
			'{KIND_DISPATCH, 8'hFF, 8'hFF, 1'b0, '0},
			'{KIND_DISPATCH, 8'h00, 8'h00, 1'b0, '0},
			'{KIND_DISPATCH, 8'h00, 8'h00, 1'b0, '0},
			'{KIND_DISPATCH, 8'h00, 8'h00, 1'b0, '0},
			'{KIND_DISPATCH, 8'h00, 8'h00, 1'b0, '0},
			'{KIND_DISPATCH, 8'h00, 8'h00, 1'b0, '0}
		};

		// hold reset, then release it at a falling edge
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, no idling
		foreach (dir_rows[r])
			send_word(dir_rows[r].kind, dir_rows[r].tid, dir_rows[r].prio,
				dir_rows[r].fixed, dir_rows[r].res);

		// random bursts that fill, drain or mix, under four idling phases
		for (int i = 0; i < RAND_WORDS; i++) begin
			if (i % PHASE_LEN == 0) begin
				case (i / PHASE_LEN)
					0:       begin send_idle_pct = 0;  stall_pct = 0;  end
					1:       begin send_idle_pct = 63; stall_pct = 0;  end
					2:       begin send_idle_pct = 0;  stall_pct = 63; end
					default: begin send_idle_pct = 22; stall_pct = 22; end
				endcase
			end
			if (i % 40 == 0)
				mix = mix_t'($urandom_range(0, 2));
			case (mix)
				MIX_FILL:  sub_pct = 80;
				MIX_DRAIN: sub_pct = 20;
				default:   sub_pct = 50;
			endcase
			k  = ($urandom_range(0, 99) < sub_pct) ? KIND_SUBMIT : KIND_DISPATCH;
			id = ID_W'($urandom_range(0, 255));
			// half the priorities from a narrow range to force ties
			pr = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3))
				: PRIO_W'($urandom_range(0, 255));
			send_word(k, id, pr, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// drain outstanding results, then a short quiet tail
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("tb: %0d submits (%0d to waiting, %0d rejected), %0d dispatches",
			n_submit, n_to_wait, n_rejected, n_dispatch);
		$display("tb: %0d dispatches on an empty list, %0d refills, %0d mismatches",
			n_empty, n_refill, errors);
		if (errors == 0 && results_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
